// ===== sv/bid_pkg.sv =====
// ----------------------------------------------------------------------------
// bid_pkg
// Shared types and constants of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bid_pkg;

  // Used-bit word geometry.
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam logic [WORD_W-1:0] ALL_USED = 32'hFFFF_FFFF;

  // Payload widths.
  localparam int ID_W   = 12;
  localparam int KIND_W = 2;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ID_W-1:0]   id_t;

  localparam kind_t KIND_ALLOCATE = 2'd0;
  localparam kind_t KIND_REGISTER = 2'd1;
  localparam kind_t KIND_FREE     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;       // write a zero word at the clear address, advance it
    logic accept;       // latch the incoming item
    logic rd_en;        // read the used-bit word
    logic rd_next;      // read the following word and advance the word index
    logic wr_rmw;       // write back the word with the target bit set or cleared
    logic wr_alloc;     // mark the found bit used and hold the result
    logic src_wbuf;     // search the word just written instead of the read data
    logic ptr_set_hit;  // move the search pointer to the found bit
    logic ptr_set_end;  // move the search pointer past the last identifier
    logic res_echo;     // result is the target, status ok
    logic res_fail;     // result is zero, status full
    logic out_load;     // move the pending result into the output register
  } bid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  tgt_in_range;
    logic  ptr_end;
    logic  hit;
    logic  cur_last;
  } bid_sts_t;

endpackage

`default_nettype wire

// ===== sv/bid_req_if.sv =====
// ----------------------------------------------------------------------------
// bid_req_if
// Request channel: operation kind and target identifier.
// ----------------------------------------------------------------------------
`default_nettype none

interface bid_req_if;
  logic             valid;
  logic             ready;
  bid_pkg::kind_t   kind;
  bid_pkg::id_t     target_id;

  modport source (output valid, output kind, output target_id, input ready);
  modport sink   (input valid, input kind, input target_id, output ready);
endinterface

`default_nettype wire

// ===== sv/bid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bid_rsp_if
// Response channel: resulting identifier and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface bid_rsp_if;
  logic           valid;
  logic           ready;
  bid_pkg::id_t   result_id;
  logic           status;

  modport source (output valid, output result_id, output status, input ready);
  modport sink   (input valid, input result_id, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/bid_ram.sv =====
// ----------------------------------------------------------------------------
// bid_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bid_ctrl.sv =====
// ----------------------------------------------------------------------------
// bid_ctrl
// Sequencer: clearing pass, decode, read-modify-write and word-by-word scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bid_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bid_pkg::bid_cmd_t      cmd,
  input  wire bid_pkg::bid_sts_t sts
);
  import bid_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_RMW    = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_NEXT   = 8'b0010_0000,
    S_FOLLOW = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind == KIND_ALLOCATE) begin
          if (sts.ptr_end) begin
            cmd.res_fail = 1'b1;
            state_next   = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = S_SCAN;
          end
        end else if ((sts.kind == KIND_REGISTER || sts.kind == KIND_FREE)
                     && sts.tgt_in_range) begin
          cmd.rd_en  = 1'b1;
          state_next = S_RMW;
        end else begin
          cmd.res_echo = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_RMW: begin
        cmd.wr_rmw   = 1'b1;
        cmd.res_echo = 1'b1;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.wr_alloc = 1'b1;
          state_next   = S_NEXT;
        end else if (sts.cur_last) begin
          cmd.res_fail = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_NEXT, S_FOLLOW: begin
        cmd.src_wbuf = (state == S_NEXT);
        if (sts.hit) begin
          cmd.ptr_set_hit = 1'b1;
          state_next      = S_DONE;
        end else if (sts.cur_last) begin
          cmd.ptr_set_end = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_FOLLOW;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting result");

  // A result appears only when an item finishes.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  // No item is taken before the clearing pass ends.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !(in_valid && in_ready) || $past(sts.clr_last))
    else $error("item accepted during clearing pass");

endmodule

`default_nettype wire

// ===== sv/bid_dpath.sv =====
// ----------------------------------------------------------------------------
// bid_dpath
// Used-bit RAM, search pointer, free-bit priority encoder and result holding.
// ----------------------------------------------------------------------------
`default_nettype none

module bid_dpath #(
  parameter int ID_COUNT = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bid_pkg::bid_cmd_t cmd,
  output bid_pkg::bid_sts_t      sts,
  input  wire bid_pkg::kind_t    in_kind,
  input  wire bid_pkg::id_t      in_target_id,
  output bid_pkg::id_t           out_id,
  output logic                   out_status
);
  import bid_pkg::*;

  localparam int WORDS   = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TAIL    = ID_COUNT % WORD_W;
  localparam int PAD_W   = 32 - WADDR_W - BIT_W;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
  localparam logic [WORD_W-1:0]  TAIL_MASK =
    (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));

  // Item and scan registers.
  kind_t              kind_q;
  id_t                target_q;
  logic [WADDR_W-1:0] cur;
  logic [WADDR_W-1:0] lo_word;
  logic [BIT_W-1:0]   lo_bit;
  logic [WADDR_W-1:0] ptr_word;
  logic [BIT_W-1:0]   ptr_bit;
  logic               ptr_end;
  logic [WORD_W-1:0]  wbuf;
  logic [WADDR_W-1:0] clr_addr;
  id_t                pend_id;
  logic               pend_status;

  logic [31:0]        tgt_in_ext;
  logic [31:0]        tgt_ext;
  logic [WADDR_W-1:0] cur_inc;
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  src;
  logic [WORD_W-1:0]  below;
  logic [WORD_W-1:0]  masked;
  logic               hit;
  logic [BIT_W-1:0]   hit_bit;
  logic [WORD_W-1:0]  hit_onehot;
  logic [WORD_W-1:0]  tgt_onehot;
  logic [31:0]        hit_full;
  logic [31:0]        lo_full;
  logic [31:0]        ptr_full;
  logic               we;
  logic [WADDR_W-1:0] waddr;
  logic [WORD_W-1:0]  wdata;
  logic [WADDR_W-1:0] raddr;

  assign tgt_in_ext = {20'd0, in_target_id};
  assign tgt_ext    = {20'd0, target_q};
  assign cur_inc    = cur + WADDR_W'(1);

  // Search the word with bits below the bound and past the last id forced used.
  assign src    = cmd.src_wbuf ? wbuf : rdata;
  assign below  = (cur == lo_word) ? ((WORD_W'(1) << lo_bit) - WORD_W'(1)) : '0;
  assign masked = src | below | ((cur == LAST_WORD) ? TAIL_MASK : '0);
  assign hit    = (masked != ALL_USED);

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  assign hit_onehot = WORD_W'(1) << hit_bit;
  assign tgt_onehot = WORD_W'(1) << target_q[BIT_W-1:0];
  assign hit_full   = {{PAD_W{1'b0}}, cur, hit_bit};
  assign lo_full    = {{PAD_W{1'b0}}, lo_word, lo_bit};
  assign ptr_full   = {{PAD_W{1'b0}}, ptr_word, ptr_bit};

  // Used-bit RAM port control.
  always_comb begin
    we    = cmd.clr_en || cmd.wr_rmw || cmd.wr_alloc;
    waddr = cmd.clr_en ? clr_addr : cur;
    wdata = '0;
    if (cmd.wr_alloc) begin
      wdata = rdata | hit_onehot;
    end else if (cmd.wr_rmw) begin
      wdata = (kind_q == KIND_REGISTER) ? (rdata | tgt_onehot) : (rdata & ~tgt_onehot);
    end
  end

  assign raddr = cmd.rd_next ? cur_inc : cur;

  bid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_used_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_word <= '0;
      ptr_bit  <= BIT_W'(1);
      ptr_end  <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + WADDR_W'(1);
      end
      if (cmd.ptr_set_hit) begin
        ptr_word <= cur;
        ptr_bit  <= hit_bit;
        ptr_end  <= 1'b0;
      end else if (cmd.ptr_set_end) begin
        ptr_end <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= in_kind;
      target_q <= in_target_id;
      lo_word  <= ptr_word;
      lo_bit   <= ptr_bit;
      cur      <= (in_kind == KIND_ALLOCATE) ? ptr_word : tgt_in_ext[BIT_W +: WADDR_W];
    end else if (cmd.rd_next) begin
      cur <= cur_inc;
    end
    if (cmd.wr_alloc) begin
      wbuf    <= wdata;
      lo_word <= cur;
      lo_bit  <= hit_bit;
    end
    if (cmd.wr_alloc) begin
      pend_id     <= hit_full[ID_W-1:0];
      pend_status <= 1'b0;
    end else if (cmd.res_echo) begin
      pend_id     <= target_q;
      pend_status <= 1'b0;
    end else if (cmd.res_fail) begin
      pend_id     <= '0;
      pend_status <= 1'b1;
    end
    if (cmd.out_load) begin
      out_id     <= pend_id;
      out_status <= pend_status;
    end
  end

  always_comb begin
    sts              = '0;
    sts.clr_last     = (clr_addr == LAST_WORD);
    sts.kind         = kind_q;
    sts.tgt_in_range = (tgt_ext < 32'(ID_COUNT));
    sts.ptr_end      = ptr_end;
    sts.hit          = hit;
    sts.cur_last     = (cur == LAST_WORD);
  end

  // The pointer names a real identifier unless it sits past the end.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    !ptr_end |-> (ptr_full < 32'(ID_COUNT)))
    else $error("search pointer out of range");

  // An allocation marks a free bit that lies at or above the search bound.
  a_alloc_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_alloc |-> (hit && hit_full >= lo_full && hit_full < 32'(ID_COUNT)))
    else $error("allocation outside search window");

  // After an allocation the pointer only moves forward.
  a_ptr_fwd: assert property (@(posedge clk) disable iff (rst)
    cmd.ptr_set_hit |-> (hit_full > lo_full))
    else $error("search pointer moved backward");

endmodule

`default_nettype wire

// ===== sv/bitmap_id_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Identifier allocator over a used-bit map with a forward-moving pointer.
// ----------------------------------------------------------------------------
// The block keeps one used bit per identifier in a RAM of 32-bit words and
// a search pointer that starts at 1 and only moves forward. Allocate hands
// out the lowest unused identifier at or above the pointer, marks it and
// moves the pointer to the next unused identifier above it; register sets a
// bit, free clears it, and both echo the target. When nothing is left,
// allocate returns status 1 with result 0 and changes nothing. After reset
// the block runs a clearing pass over all ceil(ID_COUNT/32) used-bit words
// (128 at the default size) and takes no item until it ends. Items are
// handled one at a time; the next item is taken while a finished result
// still waits in the output register. Register and free of an identifier
// in range read the used-bit word and write it back before the result is
// ready to leave; a target out of range, the unused kind code and an
// allocate with the pointer already past the end go from decode straight
// to the result. Allocate reads further used-bit words, both while looking
// for a free bit and while moving the pointer; the used-bit RAM, read one
// word per cycle through a single port, sets its pace. A finished item
// holds the block until the output register is free, and the next item
// can be taken in the cycle after its result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator #(
  parameter int ID_COUNT = 4096
) (
  input wire logic  clk,
  input wire logic  rst,
  bid_req_if.sink   req,
  bid_rsp_if.source rsp
);
  import bid_pkg::*;

  bid_cmd_t cmd;
  bid_sts_t sts;

  // Sequencer: owns the handshakes and steps the datapath.
  bid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: used-bit RAM, pointer, free-bit search and result registers.
  bid_dpath #(
    .ID_COUNT (ID_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (req.kind),
    .in_target_id (req.target_id),
    .out_id       (rsp.result_id),
    .out_status   (rsp.status)
  );

endmodule

`default_nettype wire

// ===== bench/bitmap_id_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_id_allocator_tb
// Self-checking bench for the bitmap identifier allocator.
// ----------------------------------------------------------------------------
// A queue of requests is built up front. Each request carries the response
// that a behavioral copy of the allocator predicts for it: the used bits and
// the forward-only search pointer. A clocked driver feeds the requests to
// the request channel. On every accepted request the predicted response
// moves to a scoreboard queue. A clocked monitor pops that queue on every
// accepted response and compares the result id and the status.
//
// Stimulus runs in two parts:
// - a short directed run over the edge cases;
// - about 1300 random requests built from allocate bursts, runs of
//   registrations near the search pointer, frees and noise.
// Both channels idle at random, except within one window of cycles.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bid_pkg::*;

  localparam int ID_COUNT      = 4096;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int IDLE_PERCENT  = 14;
  localparam int SETTLE_CYCLES = 200;   // covers the longest allocate scan
  localparam int STALL_LIMIT   = 3000;  // clearing pass plus a full scan, many times over
  localparam int CALM_START    = 2000;  // window of cycles with no idling at all
  localparam int CALM_END      = 5000;

  // The fourth kind code has no name in the package; the block must echo it.
  localparam kind_t KIND_UNUSED = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct {
    id_t  result_id;
    logic status;
  } response_t;

  typedef struct {
    kind_t     kind;
    id_t       target_id;
    response_t reply;
  } request_t;

  logic clk;
  logic rst;

  bid_req_if req_ch ();
  bid_rsp_if rsp_ch ();

  bitmap_id_allocator #(
    .ID_COUNT(ID_COUNT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Behavioral copy of the allocator state.
  bit          used_bits [ID_COUNT];
  int unsigned scan_ptr;

  request_t  pending_requests [$];
  response_t expected_responses [$];
  id_t       granted_ids [$];      // every identifier handed out so far

  request_t    in_flight;          // request currently offered on the channel
  int unsigned total_requests;
  int unsigned accepted_count;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned cycle_count;
  logic        calm;

  assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Lowest unused identifier at or above from, or ID_COUNT when none is left.
  function automatic int first_free(int from);
    for (int k = from; k < ID_COUNT; k++) begin
      if (!used_bits[k]) return k;
    end
    return ID_COUNT;
  endfunction

  // Apply one request to the state copy and return the response it causes.
  function automatic response_t predict_response(kind_t kind, id_t target);
    response_t r;
    int        found;
    r.result_id = target;
    r.status    = STATUS_OK;
    case (kind)
      KIND_ALLOCATE: begin
        found = first_free(scan_ptr);
        if (found >= ID_COUNT) begin
          // Map exhausted: flag it and leave everything as it is.
          r.result_id = '0;
          r.status    = STATUS_FULL;
        end else begin
          used_bits[found] = 1'b1;
          // Skip past anything registered ahead of the grant.
          scan_ptr    = first_free(found + 1);
          r.result_id = id_t'(found);
        end
      end
      KIND_REGISTER: begin
        if (int'(target) < ID_COUNT) used_bits[target] = 1'b1;
      end
      KIND_FREE: begin
        // Clearing never moves the pointer back.
        if (int'(target) < ID_COUNT) used_bits[target] = 1'b0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Predict a request's response and append both to the stimulus queue.
  task automatic queue_request(kind_t kind, id_t target);
    request_t item;
    item.kind      = kind;
    item.target_id = target;
    item.reply     = predict_response(kind, target);
    pending_requests.push_back(item);
    if (kind == KIND_ALLOCATE && item.reply.status == STATUS_OK) begin
      granted_ids.push_back(item.reply.result_id);
    end
  endtask

  // Pick an identifier that was handed out earlier, or a random one if none.
  function automatic id_t some_granted_id();
    if (granted_ids.size() == 0) return id_t'($urandom_range(ID_COUNT - 1));
    return granted_ids[$urandom_range(granted_ids.size() - 1)];
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: offer the next queued request, hold it until taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic offer;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      // The offered request was taken: its predicted response is now owed.
      if (req_ch.valid && req_ch.ready) begin
        expected_responses.push_back(in_flight.reply);
        accepted_count++;
      end
      // Advance only when the channel is free; never drop a held request.
      if (!req_ch.valid || req_ch.ready) begin
        offer = (pending_requests.size() != 0) &&
                (calm || $urandom_range(99) >= IDLE_PERCENT);
        if (offer) begin
          in_flight = pending_requests.pop_front();
          req_ch.kind      <= in_flight.kind;
          req_ch.target_id <= in_flight.target_id;
        end
        req_ch.valid <= offer;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response monitor: check each taken response against the oldest owed one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_responses
    response_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response, expected none, got id %0d status %0d",
                   $time, rsp_ch.result_id, rsp_ch.status);
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          if (rsp_ch.result_id !== want.result_id) begin
            $display("%0t: result_id mismatch, expected %0d, got %0d",
                     $time, want.result_id, rsp_ch.result_id);
            mismatches++;
          end
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp_ch.status);
            mismatches++;
          end
        end
      end
      // Stall the response side at random outside the calm window.
      rsp_ch.ready <= calm || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin : run
    int unsigned mode;
    int unsigned run_len;
    int unsigned base;
    int unsigned random_goal;

    // Every input known from time zero.
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.kind      = KIND_ALLOCATE;
    req_ch.target_id = '0;
    rsp_ch.ready     = 1'b0;
    cycle_count      = 0;
    quiet_cycles     = 0;
    accepted_count   = 0;
    mismatches       = 0;

    foreach (used_bits[k]) used_bits[k] = 1'b0;
    scan_ptr = 1;

    // Directed part.
    queue_request(KIND_ALLOCATE, '0);           // first grant is 1, never 0
    queue_request(KIND_ALLOCATE, '1);           // target ignored on allocate
    queue_request(KIND_REGISTER, '0);           // lowest identifier
    queue_request(KIND_FREE,     '0);
    queue_request(KIND_REGISTER, '1);           // highest identifier
    queue_request(KIND_UNUSED,   '1);           // unused kind echoes target
    queue_request(KIND_UNUSED,   '0);
    queue_request(KIND_REGISTER, id_t'(3));     // marked right at the pointer
    queue_request(KIND_ALLOCATE, '0);           // must skip the registered one
    queue_request(KIND_FREE,     id_t'(2));     // below the pointer
    queue_request(KIND_ALLOCATE, '0);           // pointer does not move back
    queue_request(KIND_FREE,     '0);           // free of an unused identifier
    queue_request(KIND_REGISTER, id_t'(3));     // register an identifier already used
    queue_request(KIND_REGISTER, id_t'(scan_ptr));
    queue_request(KIND_ALLOCATE, '0);
    // Registrations 30 to 69 fill a whole used-bit word ahead of the pointer.
    for (int k = 30; k < 70; k++) queue_request(KIND_REGISTER, id_t'(k));
    queue_request(KIND_ALLOCATE, '0);
    queue_request(KIND_FREE,     id_t'(ID_COUNT - 1));
    queue_request(KIND_REGISTER, id_t'(ID_COUNT - 2));

    // Random part: mostly sequences that move the pointer, with noise.
    random_goal = pending_requests.size() + RANDOM_ITEMS;
    while (pending_requests.size() < random_goal) begin
      mode = $urandom_range(99);
      if (mode < 40) begin
        // Allocate burst.
        run_len = $urandom_range(1, 8);
        repeat (run_len) queue_request(KIND_ALLOCATE, id_t'($urandom_range(ID_COUNT - 1)));
      end else if (mode < 60) begin
        // Run of registrations just ahead of the pointer, now and then a long one.
        base    = scan_ptr + $urandom_range(0, 40);
        run_len = ($urandom_range(9) == 0) ? $urandom_range(32, 70) : $urandom_range(1, 6);
        for (int k = 0; k < run_len; k++) begin
          if (base + k < ID_COUNT) queue_request(KIND_REGISTER, id_t'(base + k));
        end
      end else if (mode < 72) begin
        // Free just ahead of the pointer, often reused at once.
        base = scan_ptr + $urandom_range(0, 63);
        if (base < ID_COUNT) queue_request(KIND_FREE, id_t'(base));
        if ($urandom_range(1) == 1) queue_request(KIND_ALLOCATE, '0);
      end else if (mode < 82) begin
        queue_request(KIND_FREE, some_granted_id());
      end else if (mode < 87) begin
        queue_request(KIND_REGISTER, id_t'($urandom_range(ID_COUNT - 1)));
      end else if (mode < 94) begin
        queue_request(KIND_FREE, id_t'($urandom_range(ID_COUNT - 1)));
      end else begin
        queue_request(KIND_UNUSED, id_t'($urandom_range(ID_COUNT - 1)));
      end
    end
    total_requests = pending_requests.size();

    // Hold reset, then release it once and for all.
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: poll away from the active edge.
    do begin
      @(negedge clk);
    end while (accepted_count < total_requests || expected_responses.size() != 0);

    // Give a stray response time to show up.
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
